FILE: hw/rtl/qslerp_pkg.sv
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types, widths and constant tables of the quaternion slerp block.
// ----------------------------------------------------------------------------
package qslerp_pkg;

  // fixed point of the quaternion components
  localparam int FracBits        = 14;
  localparam int Q30Bits         = 30;
  localparam int C30Shift        = Q30Bits - 2 * FracBits;
  localparam int CordicStagesDef = 16;

  // configuration register
  localparam int              ThrW     = 15;
  localparam logic [ThrW-1:0] ThrReset = 15'd16382;

  // blend fraction
  localparam int                BlendW   = 17;
  localparam logic [BlendW-1:0] BlendOne = 17'd65536;
  localparam int                LinShift = 14;

  // integer square root chain
  localparam int SqrtSteps = 31;
  localparam int RadW      = 2 * SqrtSteps;
  localparam int RootW     = SqrtSteps;
  localparam int SqRemW    = RootW + 4;

  // cordic datapath
  localparam int                     CordW         = 34;
  localparam logic signed [CordW-1:0] CordicInvGain = 34'sd652032874;
  localparam logic [29:0] AtanTab [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

  // weight divider chain
  localparam int DivSteps = 33;
  localparam int DivRemW  = 32;
  localparam int DvsW     = RootW;
  localparam int WeightW  = 34;
  localparam int AngProdW = 50;

  typedef struct packed {
    logic signed [15:0] from_w;
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] to_w;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
    logic [16:0]        blend;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_w;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } out_t;

  // item context carried down the pipeline
  typedef struct packed {
    logic [3:0][15:0] f;
    logic [3:0][16:0] t;
    logic [16:0]      d;
    logic             lin;
  } ctx_t;

  localparam int CtxW = $bits(ctx_t);

endpackage

FILE: hw/rtl/qslerp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qslerp_sqrt_cell
// One digit step of the pipelined integer square root.
// ----------------------------------------------------------------------------
module qslerp_sqrt_cell #(
  parameter int SideW = 1
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [qslerp_pkg::RadW-1:0]  rad_i,
  input  logic [qslerp_pkg::SqRemW-1:0] rem_i,
  input  logic [qslerp_pkg::RootW-1:0] root_i,
  input  logic [SideW-1:0]             side_i,
  output logic [qslerp_pkg::RadW-1:0]  rad_o,
  output logic [qslerp_pkg::SqRemW-1:0] rem_o,
  output logic [qslerp_pkg::RootW-1:0] root_o,
  output logic [SideW-1:0]             side_o
);
  import qslerp_pkg::*;

  logic [RadW-1:0]   rad_q;
  logic [SqRemW-1:0] rem_q, part, trial;
  logic [RootW-1:0]  root_q;
  logic [SideW-1:0]  side_q;

  // bring down the next two radicand bits
  assign part  = {rem_i[SqRemW-3:0], rad_i[RadW-1 -: 2]};
  assign trial = SqRemW'({root_i, 2'b01});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= {rad_i[RadW-3:0], 2'b00};
      side_q <= side_i;
      if (part >= trial) begin
        rem_q  <= part - trial;
        root_q <= {root_i[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= part;
        root_q <= {root_i[RootW-2:0], 1'b0};
      end
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

FILE: hw/rtl/qslerp_cordic_cell.sv
// ----------------------------------------------------------------------------
// qslerp_cordic_cell
// One micro-rotation of a CORDIC, in vectoring or rotation mode.
// ----------------------------------------------------------------------------
module qslerp_cordic_cell #(
  parameter int SideW     = 1,
  parameter int Step      = 0,
  parameter bit Vectoring = 1'b0
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [qslerp_pkg::CordW-1:0] x_i,
  input  logic signed [qslerp_pkg::CordW-1:0] y_i,
  input  logic signed [qslerp_pkg::CordW-1:0] z_i,
  input  logic [SideW-1:0]                   side_i,
  output logic signed [qslerp_pkg::CordW-1:0] x_o,
  output logic signed [qslerp_pkg::CordW-1:0] y_o,
  output logic signed [qslerp_pkg::CordW-1:0] z_o,
  output logic [SideW-1:0]                   side_o
);
  import qslerp_pkg::*;

  localparam int                      Sh   = Step % 32;
  localparam logic signed [CordW-1:0] Atan = $signed({4'b0000, AtanTab[Sh]});

  logic signed [CordW-1:0] x_q, y_q, z_q, dx, dy;
  logic [SideW-1:0]        side_q;
  logic                    up;

  assign dx = y_i >>> Sh;
  assign dy = x_i >>> Sh;
  // vectoring drives y to zero, rotation drives z to zero
  assign up = Vectoring ? (y_i >= 0) : (z_i < 0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      if (up) begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + Atan;
      end else begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - Atan;
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

FILE: hw/rtl/qslerp_div_cell.sv
// ----------------------------------------------------------------------------
// qslerp_div_cell
// One quotient bit of the pipelined restoring divider.
// ----------------------------------------------------------------------------
module qslerp_div_cell #(
  parameter int SideW = 1
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [qslerp_pkg::DivSteps-1:0] num_i,
  input  logic [qslerp_pkg::DivRemW-1:0]  rem_i,
  input  logic [qslerp_pkg::DivSteps-1:0] quo_i,
  input  logic [qslerp_pkg::DvsW-1:0]     dvs_i,
  input  logic [SideW-1:0]                side_i,
  output logic [qslerp_pkg::DivSteps-1:0] num_o,
  output logic [qslerp_pkg::DivRemW-1:0]  rem_o,
  output logic [qslerp_pkg::DivSteps-1:0] quo_o,
  output logic [qslerp_pkg::DvsW-1:0]     dvs_o,
  output logic [SideW-1:0]                side_o
);
  import qslerp_pkg::*;

  logic [DivSteps-1:0] num_q, quo_q;
  logic [DivRemW-1:0]  rem_q, part, dvs_ext;
  logic [DvsW-1:0]     dvs_q;
  logic [SideW-1:0]    side_q;

  assign part    = {rem_i[DivRemW-2:0], num_i[DivSteps-1]};
  assign dvs_ext = DivRemW'(dvs_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= {num_i[DivSteps-2:0], 1'b0};
      dvs_q  <= dvs_i;
      side_q <= side_i;
      if (part >= dvs_ext) begin
        rem_q <= part - dvs_ext;
        quo_q <= {quo_i[DivSteps-2:0], 1'b1};
      end else begin
        rem_q <= part;
        quo_q <= {quo_i[DivSteps-2:0], 1'b0};
      end
    end
  end

  assign num_o  = num_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;
  assign dvs_o  = dvs_q;
  assign side_o = side_q;

endmodule

FILE: hw/rtl/quaternion_slerp.sv
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point spherical blend of two Q1.14 quaternions, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries the start and end quaternion
// and the blend fraction; output channel out_valid_o/out_ready_i carries the
// blended quaternion. A transfer happens when valid and ready are both high.
// cfg_we_i writes near_threshold from cfg_wdata_i in the same cycle; write it
// only while no item is in flight.
// Throughput: one item per cycle unless the pipeline holds. Every step (dot
// product, square root, arctangent and sine CORDICs, weight division,
// weighted sum) is a row of registered cells that all advance together.
// Most of the registers lie in the 31-step root and the 33-step divider.
// A two-entry output buffer lets the pipeline move on while a result waits.
// When the receiver stalls and the buffer fills, in_ready_o drops and the
// whole pipeline holds. Reset empties the pipeline and the buffer and loads
// near_threshold with 16382.
// ----------------------------------------------------------------------------
module quaternion_slerp #(
  parameter int CordicStages = qslerp_pkg::CordicStagesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qslerp_pkg::ThrW-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  qslerp_pkg::in_t              in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output qslerp_pkg::out_t             out_data_o
);
  import qslerp_pkg::*;

  localparam int PSqrt0 = 5;
  localparam int PVec0  = PSqrt0 + SqrtSteps;
  localparam int PAng   = PVec0 + CordicStages;
  localparam int PRot0  = PAng + 1;
  localparam int PDiv0  = PRot0 + CordicStages;
  localparam int PWgt   = PDiv0 + DivSteps;
  localparam int PPrd   = PWgt + 1;
  localparam int NStg   = PPrd + 1;

  localparam int SqSideW  = CtxW + 30;
  localparam int VecSideW = CtxW + RootW;
  localparam int DivSide0 = CtxW + 2;

  logic            adv, push, pop;
  logic [NStg-1:0] vld_q;
  logic [ThrW-1:0] thr_q;
  logic [1:0]      cnt_q;
  logic            wptr_q, rptr_q;
  out_t            buf_q [2];
  out_t            res;

  // ---------------- front stages ----------------
  ctx_t                    c1_q, c2_q, c3_q, c4_q, c5_q, c1_d, c4_d;
  logic signed [31:0]      prod2_q [4];
  logic signed [33:0]      dot3_q;
  logic [32:0]             mag4;
  logic [29:0]             c30_4_q, c30_5_q;
  logic [59:0]             sq5_q;

  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  always_comb begin
    c1_d      = '0;
    c1_d.f[0] = in_data_i.from_w;
    c1_d.f[1] = in_data_i.from_x;
    c1_d.f[2] = in_data_i.from_y;
    c1_d.f[3] = in_data_i.from_z;
    c1_d.t[0] = {in_data_i.to_w[15], in_data_i.to_w};
    c1_d.t[1] = {in_data_i.to_x[15], in_data_i.to_x};
    c1_d.t[2] = {in_data_i.to_y[15], in_data_i.to_y};
    c1_d.t[3] = {in_data_i.to_z[15], in_data_i.to_z};
    c1_d.d    = (in_data_i.blend > BlendOne) ? BlendOne : in_data_i.blend;
  end

  // shortest arc: flip the end quaternion on a negative dot product
  always_comb begin
    c4_d = c3_q;
    mag4 = dot3_q[33] ? 33'(-dot3_q) : 33'(dot3_q);
    for (int j = 0; j < 4; j++) begin
      if (dot3_q[33]) c4_d.t[j] = 17'(-$signed(c3_q.t[j]));
    end
    c4_d.lin = (mag4 > (33'(thr_q) << FracBits)) || (mag4 >= (33'(1) << (2 * FracBits)));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= c1_d;
      c2_q <= c1_q;
      for (int j = 0; j < 4; j++) begin
        prod2_q[j] <= $signed(c1_q.f[j]) * $signed(c1_q.t[j]);
      end
      c3_q    <= c2_q;
      dot3_q  <= 34'(prod2_q[0]) + 34'(prod2_q[1]) + 34'(prod2_q[2]) + 34'(prod2_q[3]);
      c4_q    <= c4_d;
      c30_4_q <= 30'(mag4 << C30Shift);
      c5_q    <= c4_q;
      c30_5_q <= c30_4_q;
      sq5_q   <= c30_4_q * c30_4_q;
    end
  end

  // ---------------- square root chain ----------------
  logic [RadW-1:0]    sq_rad  [SqrtSteps+1];
  logic [SqRemW-1:0]  sq_rem  [SqrtSteps+1];
  logic [RootW-1:0]   sq_root [SqrtSteps+1];
  logic [SqSideW-1:0] sq_side [SqrtSteps+1];
  ctx_t               sq_ctx;
  logic [29:0]        sq_c30;

  assign sq_rad[0]  = {1'b0, (61'(1) << 60) - 61'(sq5_q)};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {c5_q, c30_5_q};

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    qslerp_sqrt_cell #(.SideW(SqSideW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  assign {sq_ctx, sq_c30} = sq_side[SqrtSteps];

  // ---------------- arctangent chain ----------------
  logic signed [CordW-1:0] vx [CordicStages+1];
  logic signed [CordW-1:0] vy [CordicStages+1];
  logic signed [CordW-1:0] vz [CordicStages+1];
  logic [VecSideW-1:0]     vs [CordicStages+1];
  ctx_t                    vin_ctx, ang_ctx, ang_q;
  logic [RootW-1:0]        ang_s30, ang_s30_q;
  logic signed [31:0]      omega;
  logic signed [AngProdW-1:0] pa0_q, pa1_q;

  always_comb begin
    vin_ctx     = sq_ctx;
    vin_ctx.lin = sq_ctx.lin | (sq_root[SqrtSteps] == '0);
  end

  assign vx[0] = $signed(CordW'(sq_c30));
  assign vy[0] = $signed(CordW'(sq_root[SqrtSteps]));
  assign vz[0] = '0;
  assign vs[0] = {vin_ctx, sq_root[SqrtSteps]};

  for (genvar i = 0; i < CordicStages; i++) begin : g_vec
    qslerp_cordic_cell #(.SideW(VecSideW), .Step(i), .Vectoring(1'b1)) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .x_i    (vx[i]),
      .y_i    (vy[i]),
      .z_i    (vz[i]),
      .side_i (vs[i]),
      .x_o    (vx[i+1]),
      .y_o    (vy[i+1]),
      .z_o    (vz[i+1]),
      .side_o (vs[i+1])
    );
  end

  assign {ang_ctx, ang_s30} = vs[CordicStages];
  assign omega = 32'(vz[CordicStages]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q     <= ang_ctx;
      ang_s30_q <= ang_s30;
      pa0_q     <= $signed({1'b0, BlendOne - ang_ctx.d}) * omega;
      pa1_q     <= $signed({1'b0, ang_ctx.d}) * omega;
    end
  end

  // ---------------- sine chains ----------------
  logic signed [CordW-1:0] r0x [CordicStages+1];
  logic signed [CordW-1:0] r0y [CordicStages+1];
  logic signed [CordW-1:0] r0z [CordicStages+1];
  logic [VecSideW-1:0]     r0s [CordicStages+1];
  logic signed [CordW-1:0] r1x [CordicStages+1];
  logic signed [CordW-1:0] r1y [CordicStages+1];
  logic signed [CordW-1:0] r1z [CordicStages+1];
  logic [RootW-1:0]        r1s [CordicStages+1];

  assign r0x[0] = CordicInvGain;
  assign r0y[0] = '0;
  assign r0z[0] = CordW'(pa0_q >>> 16);
  assign r0s[0] = {ang_q, ang_s30_q};
  assign r1x[0] = CordicInvGain;
  assign r1y[0] = '0;
  assign r1z[0] = CordW'(pa1_q >>> 16);
  assign r1s[0] = ang_s30_q;

  for (genvar i = 0; i < CordicStages; i++) begin : g_rot
    qslerp_cordic_cell #(.SideW(VecSideW), .Step(i), .Vectoring(1'b0)) u_lane0 (
      .clk_i  (clk_i),
      .en_i   (adv),
      .x_i    (r0x[i]),
      .y_i    (r0y[i]),
      .z_i    (r0z[i]),
      .side_i (r0s[i]),
      .x_o    (r0x[i+1]),
      .y_o    (r0y[i+1]),
      .z_o    (r0z[i+1]),
      .side_o (r0s[i+1])
    );
    qslerp_cordic_cell #(.SideW(RootW), .Step(i), .Vectoring(1'b0)) u_lane1 (
      .clk_i  (clk_i),
      .en_i   (adv),
      .x_i    (r1x[i]),
      .y_i    (r1y[i]),
      .z_i    (r1z[i]),
      .side_i (r1s[i]),
      .x_o    (r1x[i+1]),
      .y_o    (r1y[i+1]),
      .z_o    (r1z[i+1]),
      .side_o (r1s[i+1])
    );
  end

  // ---------------- weight dividers ----------------
  ctx_t                    rot_ctx, dv_ctx;
  logic [RootW-1:0]        rot_s30;
  logic signed [CordW-1:0] sin0, sin1;
  logic [32:0]             abs0, abs1;
  logic                    neg0, neg1, ovf0, ovf1, dneg0, dneg1, dovf0, dovf1;

  logic [DivSteps-1:0] d0n [DivSteps+1];
  logic [DivRemW-1:0]  d0r [DivSteps+1];
  logic [DivSteps-1:0] d0q [DivSteps+1];
  logic [DvsW-1:0]     d0v [DivSteps+1];
  logic [DivSide0-1:0] d0s [DivSteps+1];
  logic [DivSteps-1:0] d1n [DivSteps+1];
  logic [DivRemW-1:0]  d1r [DivSteps+1];
  logic [DivSteps-1:0] d1q [DivSteps+1];
  logic [DvsW-1:0]     d1v [DivSteps+1];
  logic [1:0]          d1s [DivSteps+1];

  assign {rot_ctx, rot_s30} = r0s[CordicStages];
  assign sin0 = r0y[CordicStages];
  assign sin1 = r1y[CordicStages];
  assign neg0 = sin0[CordW-1];
  assign neg1 = sin1[CordW-1];
  assign abs0 = neg0 ? 33'(-sin0) : 33'(sin0);
  assign abs1 = neg1 ? 33'(-sin1) : 33'(sin1);
  // numerator is |sin| << 30; its top bits must stay below the divisor
  assign ovf0 = DvsW'(abs0[32:3]) >= rot_s30;
  assign ovf1 = DvsW'(abs1[32:3]) >= r1s[CordicStages];

  assign d0n[0] = {abs0[2:0], 30'd0};
  assign d0r[0] = DivRemW'(abs0[32:3]);
  assign d0q[0] = '0;
  assign d0v[0] = rot_s30;
  assign d0s[0] = {rot_ctx, neg0, ovf0};
  assign d1n[0] = {abs1[2:0], 30'd0};
  assign d1r[0] = DivRemW'(abs1[32:3]);
  assign d1q[0] = '0;
  assign d1v[0] = r1s[CordicStages];
  assign d1s[0] = {neg1, ovf1};

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    qslerp_div_cell #(.SideW(DivSide0)) u_lane0 (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (d0n[i]),
      .rem_i  (d0r[i]),
      .quo_i  (d0q[i]),
      .dvs_i  (d0v[i]),
      .side_i (d0s[i]),
      .num_o  (d0n[i+1]),
      .rem_o  (d0r[i+1]),
      .quo_o  (d0q[i+1]),
      .dvs_o  (d0v[i+1]),
      .side_o (d0s[i+1])
    );
    qslerp_div_cell #(.SideW(2)) u_lane1 (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (d1n[i]),
      .rem_i  (d1r[i]),
      .quo_i  (d1q[i]),
      .dvs_i  (d1v[i]),
      .side_i (d1s[i]),
      .num_o  (d1n[i+1]),
      .rem_o  (d1r[i+1]),
      .quo_o  (d1q[i+1]),
      .dvs_o  (d1v[i+1]),
      .side_o (d1s[i+1])
    );
  end

  assign {dv_ctx, dneg0, dovf0} = d0s[DivSteps];
  assign {dneg1, dovf1}         = d1s[DivSteps];

  // ---------------- weights and weighted sum ----------------
  localparam logic [32:0] WeightLim = 33'(1) << 32;

  logic [32:0]               m0, m1;
  logic signed [WeightW-1:0] k0, k1, k0_q, k1_q;
  ctx_t                      cw_q;
  logic signed [50:0]        pf_q [4];
  logic signed [50:0]        pt_q [4];
  logic signed [51:0]        acc  [4];
  logic signed [21:0]        rnd  [4];
  logic signed [15:0]        sat  [4];

  always_comb begin
    m0 = (dovf0 || (d0q[DivSteps] > WeightLim)) ? WeightLim : d0q[DivSteps];
    m1 = (dovf1 || (d1q[DivSteps] > WeightLim)) ? WeightLim : d1q[DivSteps];
    if (dv_ctx.lin) begin
      k0 = $signed(WeightW'(BlendOne - dv_ctx.d) << LinShift);
      k1 = $signed(WeightW'(dv_ctx.d) << LinShift);
    end else begin
      k0 = dneg0 ? -$signed({1'b0, m0}) : $signed({1'b0, m0});
      k1 = dneg1 ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cw_q <= dv_ctx;
      k0_q <= k0;
      k1_q <= k1;
      for (int j = 0; j < 4; j++) begin
        pf_q[j] <= $signed(cw_q.f[j]) * k0_q;
        pt_q[j] <= $signed(cw_q.t[j]) * k1_q;
      end
    end
  end

  // round at bit 29, then saturate to 16 bits
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc[j] = 52'(pf_q[j]) + 52'(pt_q[j]) + (52'sd1 <<< 29);
      rnd[j] = 22'(acc[j] >>> 30);
      if (rnd[j] > 22'sd32767)       sat[j] = 16'sd32767;
      else if (rnd[j] < -22'sd32768) sat[j] = -16'sd32768;
      else                           sat[j] = 16'(rnd[j]);
    end
    res.out_w = sat[0];
    res.out_x = sat[1];
    res.out_y = sat[2];
    res.out_z = sat[3];
  end

  // ---------------- control, register, output buffer ----------------
  assign push        = adv && vld_q[PPrd];
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      thr_q  <= ThrReset;
      cnt_q  <= 2'd0;
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (adv) vld_q <= {vld_q[NStg-2:0], in_valid_i};
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wptr_q] <= res;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push)
    else $error("result pushed into a full output buffer");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transfer missing from first stage");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1 && pop && !push) |=> !out_valid_o)
    else $error("output still valid after last result left");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quaternion_slerp: directed corner cases, several
// threshold settings and random blends, checked against a bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import qslerp_pkg::*;

  localparam int  Latency    = 2 * CordicStagesDef + 72;
  localparam int  CycleLimit = 400000;
  localparam real Idle       = 0.24;
  localparam int  InW        = $bits(in_t);

  localparam logic signed [63:0] InvGain = 64'sd652032874;
  localparam logic signed [63:0] WLimit  = 64'sd1 <<< 32;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [ThrW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  in_t             in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_t            out_data_o;

  quaternion_slerp dut (.*);

  logic [ThrW-1:0] thresh = ThrReset;
  out_t            expected_q[$];
  int              errors = 0;
  int              n_sent = 0;
  int              n_checked = 0;
  int              cycles = 0;
  bit              quiet_in = 1'b0;
  bit              quiet_out = 1'b0;
  int              hold_off = 0;

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout at %0t", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] arc_angle(logic signed [63:0] x,
                                                   logic signed [63:0] y);
    logic signed [63:0] z, dx, dy;
    z = 0;
    for (int i = 0; i < CordicStagesDef; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += AtanTab[i];
      end else begin
        x -= dx; y += dy; z -= AtanTab[i];
      end
    end
    return z;
  endfunction

  function automatic logic signed [63:0] sine_of(logic signed [63:0] z);
    logic signed [63:0] x, y, dx, dy;
    x = InvGain;
    y = 0;
    for (int i = 0; i < CordicStagesDef; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    return y;
  endfunction

  function automatic logic signed [63:0] clip_weight(logic signed [63:0] k);
    if (k > WLimit) return WLimit;
    if (k < -WLimit) return -WLimit;
    return k;
  endfunction

  function automatic out_t slerp_predict(in_t q);
    logic signed [63:0] f[4], t[4], dot, k0, k1, omega, a0, a1, r;
    logic [63:0]        d, c30, s30;
    out_t               res;
    bit                 linear;
    f = '{q.from_w, q.from_x, q.from_y, q.from_z};
    t = '{q.to_w, q.to_x, q.to_y, q.to_z};
    dot = 0;
    for (int j = 0; j < 4; j++) dot += f[j] * t[j];
    if (dot < 0) begin
      for (int j = 0; j < 4; j++) t[j] = -t[j];
      dot = -dot;
    end
    d = (q.blend > BlendOne) ? 64'(BlendOne) : 64'(q.blend);
    linear = (dot > (64'(thresh) << FracBits)) || (dot >= (64'sd1 << 28));
    s30 = 0;
    if (!linear) begin
      c30 = 64'(dot) << C30Shift;
      if (c30 > (64'd1 << 30)) c30 = 64'd1 << 30;
      s30 = int_sqrt((64'd1 << 60) - c30 * c30);
      linear = (s30 == 0);
    end
    if (linear) begin
      k0 = (65536 - d) << 14;
      k1 = d << 14;
    end else begin
      omega = arc_angle(c30, s30);
      a1 = floor_shr($signed(d) * omega, 16);
      a0 = floor_shr($signed(65536 - d) * omega, 16);
      k0 = clip_weight((sine_of(a0) <<< 30) / $signed(s30));
      k1 = clip_weight((sine_of(a1) <<< 30) / $signed(s30));
    end
    for (int j = 0; j < 4; j++) begin
      r = floor_shr(f[j] * k0 + t[j] * k1 + (64'sd1 <<< 29), 30);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      unique case (j)
        0: res.out_w = r[15:0];
        1: res.out_x = r[15:0];
        2: res.out_y = r[15:0];
        default: res.out_z = r[15:0];
      endcase
    end
    return res;
  endfunction

  // receiver: random stall, quiet stretch, or a counted hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet_out || ($urandom_range(99) >= 24);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, out_data_o);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        n_checked++;
        if (out_data_o.out_w !== exp_r.out_w)
          $display("%0t: w exp %0d got %0d", $time, exp_r.out_w, out_data_o.out_w);
        if (out_data_o.out_x !== exp_r.out_x)
          $display("%0t: x exp %0d got %0d", $time, exp_r.out_x, out_data_o.out_x);
        if (out_data_o.out_y !== exp_r.out_y)
          $display("%0t: y exp %0d got %0d", $time, exp_r.out_y, out_data_o.out_y);
        if (out_data_o.out_z !== exp_r.out_z)
          $display("%0t: z exp %0d got %0d", $time, exp_r.out_z, out_data_o.out_z);
        if (out_data_o !== exp_r) errors++;
      end
    end
  end

  // valid drops only on an idle cycle, so back-to-back items keep it high
  task automatic send_item(in_t q);
    if (!quiet_in) begin
      while ($urandom_range(99) < 24) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(slerp_predict(q));
    n_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [ThrW-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    thresh = v;
  endtask

  function automatic in_t make_item(logic signed [15:0] fw, fx, fy, fz, tw, tx, ty, tz,
                                    logic [16:0] bl);
    in_t q;
    q = '{fw, fx, fy, fz, tw, tx, ty, tz, bl};
    return q;
  endfunction

  // start quaternion with |w|+|x|+|y| of one and z zero, end near it, sometimes negated
  function automatic in_t unit_pair(logic [16:0] bl);
    int a, b;
    in_t q;
    q = '0;
    q.blend = bl;
    a = $urandom_range(16384);
    b = $urandom_range(16384 - a);
    q.from_w = 16'(a);
    q.from_x = 16'(16384 - a - b);
    q.from_y = $urandom_range(1) ? 16'(b) : -16'(b);
    q.from_z = 0;
    q.to_w   = q.from_w + $signed(16'($urandom_range(4000))) - 16'sd2000;
    q.to_x   = q.from_x + $signed(16'($urandom_range(4000))) - 16'sd2000;
    q.to_y   = q.from_y;
    q.to_z   = $signed(16'($urandom_range(3000))) - 16'sd1500;
    if ($urandom_range(1)) begin
      q.to_w = -q.to_w; q.to_x = -q.to_x; q.to_y = -q.to_y; q.to_z = -q.to_z;
    end
    return q;
  endfunction

  task automatic test_directed;
    send_item(make_item(16384, 0, 0, 0, 16384, 0, 0, 0, 0));
    send_item(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 32768));
    send_item(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 65536));
    send_item(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 17'h1FFFF));
    send_item(make_item(16384, 0, 0, 0, -16384, 0, 0, 0, 20000));
    send_item(make_item(16384, 0, 0, 0, -11585, 11585, 0, 0, 40000));
    send_item(make_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        30000));
    send_item(make_item(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768,
                        65536));
    send_item(make_item(-32768, 0, 0, 0, 32767, 0, 0, 0, 1));
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 65535));
    send_item(make_item(16384, 0, 0, 0, 16383, 181, 0, 0, 50000));
    send_item(make_item(16384, 0, 0, 0, 100, 0, 16383, 0, 12345));
    send_item(make_item(100, 0, 0, 0, 0, 0, 0, 100, 65536));
    send_item(make_item(1, -1, 1, -1, 32767, -32768, 1, 0, 17'h10001));
    send_item(make_item(16384, 0, 0, 0, 11585, 0, 0, 11585, 0));
  endtask

  task automatic test_thresholds;
    logic [ThrW-1:0] vals[4] = '{15'd0, 15'd16384, 15'd8000, ThrReset};
    foreach (vals[i]) begin
      set_threshold(vals[i]);
      for (int k = 0; k < 12; k++) send_item(unit_pair(17'($urandom_range(65536))));
      send_item(make_item(16384, 0, 0, 0, 16384, 0, 0, 0, 30000));
      send_item(make_item(16384, 0, 0, 0, 16000, 3000, 0, 0, 30000));
    end
  endtask

  task automatic test_random;
    in_t q;
    for (int i = 0; i < 460; i++) begin
      quiet_in  = (i >= 150 && i < 230);
      quiet_out = quiet_in;
      if (i == 300) hold_off = 300;
      if ($urandom_range(99) < 80) begin
        q = unit_pair($urandom_range(99) < 10 ? 17'($urandom) : 17'($urandom_range(65536)));
      end else begin
        q = InW'({$urandom, $urandom, $urandom, $urandom, $urandom});
      end
      send_item(q);
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_thresholds();
    test_random();
    drain();
    $display("sent %0d items, checked %0d results, over four threshold settings",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
